FILE: rtl/core/label_centroid_accumulator_core_macros.svh
// assertion macros used by the top-level rtl file
`ifndef LABEL_CENTROID_ACCUMULATOR_CORE_MACROS_SVH
`define LABEL_CENTROID_ACCUMULATOR_CORE_MACROS_SVH
// implication checked every clock outside reset
`define LCA_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// implication with the consequent checked in the following clock
`define LCA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: rtl/core/lca_pkg.sv
// shared constants and types for the label centroid accumulator
`timescale 1ns / 1ps
package lca_pkg;
  localparam int unsigned NumLabelsDef = 1024;
  localparam int unsigned CntW = 32;
  localparam int unsigned SumW = 48;
  localparam int unsigned CtrW = 24;
  localparam int unsigned LabelW = 32;
  localparam int unsigned CoordW = 16;
  localparam logic OpAccum = 1'b0;
  localparam logic OpReport = 1'b1;
  localparam logic [0:0] RegMinVolume = 1'b0;

  typedef struct packed {
    logic [SumW-1:0] sum_z;
    logic [SumW-1:0] sum_y;
    logic [SumW-1:0] sum_x;
    logic [CntW-1:0] count;
    logic            kept;
  } lca_div_req_t;

  typedef struct packed {
    logic [CtrW-1:0] centre_z;
    logic [CtrW-1:0] centre_y;
    logic [CtrW-1:0] centre_x;
  } lca_div_res_t;
endpackage

FILE: rtl/core/lca_divider.sv
// three-lane restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module lca_divider (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  lca_pkg::lca_div_req_t req,
  output logic                  done,
  output lca_pkg::lca_div_res_t res
);
  import lca_pkg::*;

  localparam int unsigned DivW = SumW + 8;
  localparam int unsigned StepW = $clog2(DivW + 1);

  logic [DivW-1:0] num_r [3];
  logic [CntW:0]   rem_r [3];
  logic [CntW-1:0] den_r;
  logic            kept_r;
  logic [StepW-1:0] step_r;
  logic            busy_r;
  logic            done_r;

  logic [DivW-1:0] num_nxt [3];
  logic [CntW:0]   rem_nxt [3];

  always_comb begin
    logic [CntW:0] sh;
    for (int i = 0; i < 3; i++) begin
      sh = {rem_r[i][CntW-1:0], num_r[i][DivW-1]};
      num_nxt[i] = {num_r[i][DivW-2:0], 1'b0};
      if (sh >= {1'b0, den_r}) begin
        rem_nxt[i] = sh - {1'b0, den_r};
        num_nxt[i][0] = 1'b1;
      end else begin
        rem_nxt[i] = sh;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == StepW'(DivW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r[0] <= {req.sum_z, 8'h00};
      num_r[1] <= {req.sum_y, 8'h00};
      num_r[2] <= {req.sum_x, 8'h00};
      for (int i = 0; i < 3; i++) rem_r[i] <= '0;
      // zero count only reaches here with kept low; avoid a zero divisor
      den_r  <= (req.count == '0) ? CntW'(1) : req.count;
      kept_r <= req.kept;
    end else if (busy_r) begin
      for (int i = 0; i < 3; i++) begin
        num_r[i] <= num_nxt[i];
        rem_r[i] <= rem_nxt[i];
      end
    end
  end

  assign done = done_r;
  assign res.centre_z = kept_r ? num_r[0][CtrW-1:0] : '0;
  assign res.centre_y = kept_r ? num_r[1][CtrW-1:0] : '0;
  assign res.centre_x = kept_r ? num_r[2][CtrW-1:0] : '0;
endmodule

FILE: rtl/core/label_centroid_accumulator_core.sv
// top level: per-label centroid accumulator with table memory and divider
`timescale 1ns / 1ps
// Accumulates z, y, x coordinate sums and voxel counts per label in one
// synchronous table memory (one read, one write port, registered read).
// After reset a clearing pass writes every entry while no word is
// accepted; min_volume writes are taken during it. Accumulate words are
// accepted back to back: the read-modify-write runs as a two-stage
// pipeline with the just-written entry forwarded to a following word of
// the same label. A report word reads the entry, clears it for a valid
// label and runs a 56-step shared restoring divider. Intake stays closed
// until the result is taken.
module label_centroid_accumulator_core #(
  parameter int unsigned NUM_LABELS = lca_pkg::NumLabelsDef
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_opcode,
  input  logic [lca_pkg::LabelW-1:0] in_label,
  input  logic [lca_pkg::CoordW-1:0] in_coord_z,
  input  logic [lca_pkg::CoordW-1:0] in_coord_y,
  input  logic [lca_pkg::CoordW-1:0] in_coord_x,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [lca_pkg::LabelW-1:0] out_report_label,
  output logic [lca_pkg::CtrW-1:0]   out_centre_z,
  output logic [lca_pkg::CtrW-1:0]   out_centre_y,
  output logic [lca_pkg::CtrW-1:0]   out_centre_x,
  output logic [lca_pkg::CntW-1:0]   out_voxel_count,
  output logic                       out_kept,
  output logic                       out_overflowed,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [1:0]                 cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);
  import lca_pkg::*;
  `include "label_centroid_accumulator_core_macros.svh"

  localparam int unsigned AddrW = $clog2(NUM_LABELS);
  localparam int unsigned EntW = CntW + 3 * SumW + 1;

  typedef enum logic [1:0] {ST_CLEAR, ST_RUN, ST_DIV, ST_HOLD} state_t;

  // entry layout: {ovf, count, sum_z, sum_y, sum_x}
  logic [EntW-1:0] mem [NUM_LABELS];
  logic [EntW-1:0] rd_data_r;

  state_t state_r;
  logic [AddrW:0] clr_r;
  logic [31:0] min_volume_r;

  // stage 1 (read issued)
  logic            s1_v_r;
  logic            s1_op_r;
  logic            s1_ok_r;
  logic [AddrW-1:0] s1_addr_r;
  logic [LabelW-1:0] s1_label_r;
  logic [CoordW-1:0] s1_z_r, s1_y_r, s1_x_r;

  // last write for forwarding
  logic            wb_v_r;
  logic [AddrW-1:0] wb_addr_r;
  logic [EntW-1:0] wb_data_r;

  logic [LabelW-1:0] out_label_r;
  logic [CntW-1:0]   out_count_r;
  logic              out_kept_r, out_ovf_r, out_valid_r;
  logic              out_zero_r;

  lca_div_req_t div_req;
  lca_div_res_t div_res;
  logic         div_start, div_done;

  logic            in_fire;
  logic            in_ok;
  logic [EntW-1:0] cur;
  logic [CntW-1:0] cur_cnt;
  logic            cur_ovf;
  logic [SumW-1:0] cur_sz, cur_sy, cur_sx;
  logic            keep;
  logic            mem_we;
  logic [AddrW-1:0] mem_wa;
  logic [EntW-1:0] mem_wd;
  logic            s1_report;

  assign in_ok = (in_label != '0) && (in_label < LabelW'(NUM_LABELS));
  // a report in stage 1 stalls intake until its result is delivered
  assign s1_report = s1_v_r && (s1_op_r == OpReport);
  assign in_ready = (state_r == ST_RUN) && !s1_report;
  assign in_fire = in_valid && in_ready;

  assign cur = (wb_v_r && wb_addr_r == s1_addr_r) ? wb_data_r : rd_data_r;
  assign cur_ovf = cur[EntW-1];
  assign cur_cnt = cur[EntW-2 -: CntW];
  assign cur_sz = cur[3*SumW-1 -: SumW];
  assign cur_sy = cur[2*SumW-1 -: SumW];
  assign cur_sx = cur[SumW-1:0];
  assign keep = (cur_cnt != '0) && (cur_cnt >= min_volume_r);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = s1_addr_r;
    mem_wd = '0;
    if (state_r == ST_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_r[AddrW-1:0];
    end else if (s1_v_r && s1_ok_r && state_r == ST_RUN) begin
      mem_we = 1'b1;
      if (s1_op_r == OpAccum) begin
        if (cur_cnt == '1) mem_wd = {1'b1, cur[EntW-2:0]};
        else mem_wd = {cur_ovf, cur_cnt + 1'b1, cur_sz + SumW'(s1_z_r),
                       cur_sy + SumW'(s1_y_r), cur_sx + SumW'(s1_x_r)};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_data_r <= mem[in_label[AddrW-1:0]];
  end

  assign div_start = s1_report && state_r == ST_RUN;
  assign div_req.sum_z = cur_sz;
  assign div_req.sum_y = cur_sy;
  assign div_req.sum_x = cur_sx;
  assign div_req.count = cur_cnt;
  assign div_req.kept = keep && s1_ok_r;

  lca_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .req(div_req),
    .done(div_done), .res(div_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r <= '0;
      min_volume_r <= '0;
      s1_v_r <= 1'b0;
      wb_v_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[1:1] == RegMinVolume)
        min_volume_r <= cfg_pwdata;
      wb_v_r <= mem_we && state_r != ST_CLEAR;
      wb_addr_r <= mem_wa;
      wb_data_r <= mem_wd;
      case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == (AddrW+1)'(NUM_LABELS - 1)) state_r <= ST_RUN;
        end
        ST_RUN: begin
          if (div_start) begin
            state_r <= ST_DIV;
            out_label_r <= s1_label_r;
            out_count_r <= s1_ok_r ? cur_cnt : '0;
            out_kept_r <= s1_ok_r && keep;
            out_ovf_r <= s1_ok_r && cur_ovf;
            out_zero_r <= 1'b0;
          end else begin
            s1_v_r <= in_fire;
          end
          if (in_fire) begin
            s1_op_r <= in_opcode;
            s1_ok_r <= in_ok;
            s1_addr_r <= in_label[AddrW-1:0];
            s1_label_r <= in_label;
            s1_z_r <= in_coord_z;
            s1_y_r <= in_coord_y;
            s1_x_r <= in_coord_x;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state_r <= ST_HOLD;
            out_valid_r <= 1'b1;
          end
        end
        ST_HOLD: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            s1_v_r <= 1'b0;
            state_r <= ST_RUN;
          end
        end
        default: state_r <= ST_CLEAR;
      endcase
    end
  end

  logic [CtrW-1:0] cz_r, cy_r, cx_r;
  always_ff @(posedge clk) begin
    if (div_done) begin
      cz_r <= div_res.centre_z;
      cy_r <= div_res.centre_y;
      cx_r <= div_res.centre_x;
    end
  end

  assign out_valid = out_valid_r;
  assign out_report_label = out_label_r;
  assign out_centre_z = out_zero_r ? '0 : cz_r;
  assign out_centre_y = out_zero_r ? '0 : cy_r;
  assign out_centre_x = out_zero_r ? '0 : cx_r;
  assign out_voxel_count = out_count_r;
  assign out_kept = out_kept_r;
  assign out_overflowed = out_ovf_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = min_volume_r;

  `LCA_ASSERT_IMP(a_no_intake_busy, state_r != ST_RUN, !in_ready, "intake open while busy")
  `LCA_ASSERT_IMP(a_out_only_hold, out_valid, state_r == ST_HOLD, "result outside hold")
  `LCA_ASSERT_NEXT(a_div_done_valid, div_done && state_r == ST_DIV, out_valid, "result lost")
  `LCA_ASSERT_IMP(a_unkept_zero, out_valid && !out_kept, out_centre_z == '0 && out_centre_x == '0,
    "unkept centre not zero")
endmodule
